// ----- rtl/csc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, constants and helpers of the caseless substring counter.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int COUNT_WIDTH = 24;

    localparam int BYTE_W      = 8;
    localparam int PAT_BYTES   = 16;
    localparam int PIDX_W      = 4;
    localparam int LEN_W       = 5;
    localparam int SEEN_W      = $clog2(MAX_PATTERN + 1);
    localparam int OUT_COUNT_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // queue depth must stay a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              text_end;
    } t_in_item;

    typedef struct packed {
        logic                   match_here;
        logic [OUT_COUNT_W-1:0] match_count;
        logic                   count_final;
    } t_out_item;

    typedef struct packed {
        logic [PAT_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                 length;
    } t_pattern;

    typedef struct packed {
        logic [BYTE_W-1:0] folded;
        logic              last;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_head;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5a) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- rtl/csc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_front
// Accepts text items, folds letter case and holds them in a short queue.
// ----------------------------------------------------------------------------
module csc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  csc_pkg::t_in_item i_item,
    input  logic              i_pop,
    output csc_pkg::t_q_head  o_head
);
    import csc_pkg::*;

    t_q_entry          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push;
    logic              pop;
    t_q_entry          in_entry;

    assign o_stall = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != '0);

    assign in_entry.folded = fold_case(i_item.text_byte);
    assign in_entry.last   = i_item.text_end;

    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rptr];

    always_comb begin
        n_wptr = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = pop ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= in_entry;
        end
    end

endmodule

// ----- rtl/csc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_back
// Shifts the byte window, compares it with the pattern in parallel,
// keeps the per-text count and holds the result register.
// ----------------------------------------------------------------------------
module csc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csc_pkg::t_q_head   i_head,
    output logic               o_pop,
    input  csc_pkg::t_pattern  i_pattern,
    output logic               o_valid,
    input  logic               i_stall,
    output csc_pkg::t_out_item o_item
);
    import csc_pkg::*;

    logic [BYTE_W-1:0]      r_win [MAX_PATTERN];
    logic [BYTE_W-1:0]      n_win [MAX_PATTERN];
    logic [SEEN_W-1:0]      r_seen, n_seen;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_out_valid;
    t_out_item              r_out;
    logic                   hit;
    logic                   len_ok;
    logic [PIDX_W-1:0]      pidx [MAX_PATTERN];
    logic [31:0]            count_ext;

    assign o_pop   = i_head.valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        n_win[0] = i_head.entry.folded;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_seen = (int'(r_seen) < MAX_PATTERN) ? r_seen + 1'b1 : r_seen;
    end

    // window slot k lines up with pattern byte length-1-k
    always_comb begin
        len_ok = (i_pattern.length != '0)
              && (int'(i_pattern.length) <= MAX_PATTERN)
              && (int'(n_seen) >= int'(i_pattern.length));
        hit = len_ok;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pidx[k] = PIDX_W'(i_pattern.length - LEN_W'(k + 1));
            if (LEN_W'(k) < i_pattern.length &&
                n_win[k] != fold_case(i_pattern.bytes[pidx[k]])) begin
                hit = 1'b0;
            end
        end
        n_count = r_count;
        if (hit && r_count != '1) begin
            n_count = r_count + 1'b1;
        end
        count_ext = 32'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                if (i_head.entry.last) begin
                    r_seen  <= '0;
                    r_count <= '0;
                end else begin
                    r_seen  <= n_seen;
                    r_count <= n_count;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window contents beyond the fill count are never compared
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_win                <= n_win;
            r_out.match_here     <= hit;
            r_out.match_count    <= count_ext[OUT_COUNT_W-1:0];
            r_out.count_final    <= i_head.entry.last;
        end
    end

endmodule

// ----- rtl/caseless_substring_counter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caseless_substring_counter_core
// Counts overlapping, case-insensitive occurrences of a pattern of up to
// sixteen bytes in a byte stream, one text at a time.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  text in  | in        | i_valid / o_stall       | i_item  (t_in_item)
//  result   | out       | o_valid / i_stall       | o_item  (t_out_item)
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one item per cycle sustained while results are not stalled; the window compare
//  over all sixteen slots is combinational in the back end
//  each item is held in the front queue, then in the result register
//  reset is synchronous and clears pattern, length, fill count and count
//  the two-entry queue lets the input take items until it is full while a result is stalled
//  config writes are always taken
// ----------------------------------------------------------------------------
module caseless_substring_counter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  csc_pkg::t_in_item                i_item,
    output logic                             o_valid,
    input  logic                             i_stall,
    output csc_pkg::t_out_item               o_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [csc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [csc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import csc_pkg::*;

    t_pattern r_pattern;
    t_q_head  head;
    logic     pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PAT_LOW:  r_pattern.bytes[7:0]  <= i_cfg_data;
                CFG_PAT_HIGH: r_pattern.bytes[15:8] <= i_cfg_data;
                CFG_PAT_LEN:  r_pattern.length      <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    csc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_head  (head)
    );

    csc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .o_pop     (pop),
        .i_pattern (r_pattern),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

    // a full queue always has an item to offer the back end
    a_stall_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> head.valid)
        else $error("input stalled with empty queue");

    // back end never overwrites a held result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !(o_valid && i_stall))
        else $error("result overwritten while stalled");

    // a pop with a waiting head always yields a result next cycle
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_valid)
        else $error("popped item produced no result");

    // a reported match is counted
    a_match_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (COUNT_WIDTH <= OUT_COUNT_W) && o_valid && o_item.match_here
            |-> o_item.match_count != '0)
        else $error("match with zero count");

endmodule

// ----- bench/caseless_substring_counter_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caseless_substring_counter_core_tb
// Streams text bytes through the substring counter under random idling on
// both channels and checks every result against a cycle-free model of the
// folded window compare, the per-text tally and the text_end clear.
// ----------------------------------------------------------------------------
module caseless_substring_counter_core_tb;

    import csc_pkg::*;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PHASE_ITEMS  = 125;
    localparam logic [31:0] TALLY_MAX    = (32'd1 << COUNT_WIDTH) - 32'd1;
    // index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        t_in_item item;
        bit       hold;
    } t_text_slot;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_in_item              i_item      = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_out_item             o_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    caseless_substring_counter_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model state
    logic [63:0]  pat_lo   = '0;
    logic [63:0]  pat_hi   = '0;
    logic [4:0]   pat_len  = '0;
    logic [7:0]   window [MAX_PATTERN];
    int           fill;
    logic [31:0]  tally;

    t_text_slot   pending_text[$];
    t_out_item    awaited_results[$];
    t_text_slot   next_slot;
    int           queued        = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           errors        = 0;
    int           cycles        = 0;
    logic         in_taken      = 1'b0;
    logic         cfg_taken     = 1'b0;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
    endfunction

    function automatic void clear_text();
        for (int k = 0; k < MAX_PATTERN; k++) begin
            window[k] = '0;
        end
        fill  = 0;
        tally = '0;
    endfunction

    function automatic t_out_item scan_byte(input t_in_item it);
        t_out_item    r;
        logic         hit;
        int           n;
        logic [127:0] pat_all;
        pat_all = {pat_hi, pat_lo};
        for (int k = MAX_PATTERN - 1; k > 0; k--) begin
            window[k] = window[k-1];
        end
        window[0] = lower_ascii(it.text_byte);
        if (fill < MAX_PATTERN) begin
            fill++;
        end
        n   = int'(pat_len);
        hit = (n >= 1 && n <= MAX_PATTERN && fill >= n);
        // newest window byte lines up with the last pattern byte
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (hit && k < n && window[k] != lower_ascii(pat_all[8*(n-1-k) +: 8])) begin
                hit = 1'b0;
            end
        end
        if (hit && tally < TALLY_MAX) begin
            tally++;
        end
        r.match_here  = hit;
        r.match_count = tally[OUT_COUNT_W-1:0];
        r.count_final = it.text_end;
        if (it.text_end) begin
            clear_text();
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [7:0] sample_char();
        case ($urandom_range(11))
            0:       return 8'h61;
            1:       return 8'h41;
            2:       return 8'h62;
            3:       return 8'h42;
            4:       return 8'h7a;
            5:       return 8'h5a;
            6:       return 8'h40;
            7:       return 8'h5b;
            8:       return 8'h60;
            9:       return 8'h7b;
            10:      return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        if (low >= 8'h61 && low <= 8'h7a && $urandom_range(1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    task automatic push_text(input logic [7:0] c, input logic last, input bit hold);
        t_text_slot s;
        s.item.text_byte = c;
        s.item.text_end  = last;
        s.hold           = hold;
        pending_text.push_back(s);
        queued++;
    endtask

    // half pattern copies with random case, some broken, the rest noise
    task automatic fill_phase(input int amount, input logic [127:0] pat, input int plen);
        int         target;
        int         mid;
        int         span;
        int         cut;
        logic [7:0] c;
        target = queued + amount;
        mid    = queued + amount / 2;
        while (queued < target) begin
            case ($urandom_range(99)) inside
                [0:49]: begin
                    span = (plen >= 1 && plen <= MAX_PATTERN) ? plen : $urandom_range(1, 16);
                    cut  = ($urandom_range(9) == 0) ? $urandom_range(span - 1) : span;
                    for (int k = 0; k < cut; k++) begin
                        c = flip_case(pat[8*k +: 8]);
                        if ($urandom_range(19) == 0) begin
                            c = 8'($urandom_range(255));
                        end
                        push_text(c, $urandom_range(99) < 3, queued == mid);
                    end
                end
                [50:84]: begin
                    repeat ($urandom_range(1, 4)) begin
                        push_text(sample_char(), $urandom_range(99) < 3, queued == mid);
                    end
                end
                default: begin
                    push_text(8'($urandom_range(255)), $urandom_range(99) < 3, queued == mid);
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_text.size() != 0 || i_valid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // driver: inputs move on the falling edge only
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct
                        && !(pending_text[0].hold && awaited_results.size() != 0)) begin
                    next_slot = pending_text.pop_front();
                    i_item  <= next_slot.item;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: handshakes sampled on the rising edge
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        in_taken  <= i_valid && !o_stall;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        cycles    <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_PAT_LOW:  pat_lo  = i_cfg_data;
                    CFG_PAT_HIGH: pat_hi  = i_cfg_data;
                    CFG_PAT_LEN:  pat_len = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                awaited_results.push_back(scan_byte(i_item));
            end
            if (o_valid && !i_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result item with nothing expected: %p", o_item);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("match_here", 32'(want.match_here),
                                32'(o_item.match_here));
                    check_field("match_count", 32'(want.match_count),
                                32'(o_item.match_count));
                    check_field("count_final", 32'(want.count_final),
                                32'(o_item.count_final));
                end
            end
        end
    end

    initial begin
        logic [127:0] pat;
        logic [127:0] text;
        logic [63:0]  lendata;
        int           plen;
        clear_text();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 71;

        // pattern "AbAb": overlapping hits, short text, no hit across texts
        write_reg(CFG_PAT_LOW, 64'h0000_0000_6241_6241);
        write_reg(CFG_PAT_HIGH, 64'h0);
        write_reg(CFG_PAT_LEN, 64'd4);
        push_text(8'h61, 1'b0, 1'b0);
        push_text(8'h42, 1'b0, 1'b0);
        push_text(8'h61, 1'b0, 1'b0);
        push_text(8'h42, 1'b0, 1'b0);
        push_text(8'h61, 1'b0, 1'b0);
        push_text(8'h62, 1'b1, 1'b0);
        push_text(8'h61, 1'b0, 1'b0);
        push_text(8'h42, 1'b0, 1'b0);
        push_text(8'h61, 1'b1, 1'b0);
        push_text(8'h62, 1'b1, 1'b0);
        wait_drained();

        // full sixteen byte pattern with fold boundaries and non-letters
        write_reg(CFG_PAT_LOW, 64'h005a_7a7b_605b_4051);
        write_reg(CFG_PAT_HIGH, 64'h4178_39c1_804d_61ff);
        write_reg(CFG_PAT_LEN, 64'd16);
        text = 128'h615839c1806d41ff_007a5a7b605b4071;
        for (int k = 0; k < 16; k++) begin
            push_text(text[8*k +: 8], k == 15, 1'b0);
        end

        for (int p = 0; p < 12; p++) begin
            wait_drained();
            send_idle_pct = (p < 4) ? 7 : (p < 8) ? 71 : 0;
            recv_idle_pct = (p < 4) ? 71 : (p < 8) ? 7 : 0;
            case (p)
                0:       plen = 1;
                1:       plen = 2;
                2:       plen = 3;
                3:       plen = 16;
                4:       plen = 0;
                5:       plen = 4;
                6:       plen = 17;
                7:       plen = 16;
                8:       plen = 31;
                9:       plen = 5;
                10:      plen = $urandom_range(1, 16);
                default: plen = 8;
            endcase
            for (int k = 0; k < 16; k++) begin
                pat[8*k +: 8] = ($urandom_range(5) == 0) ? 8'($urandom_range(255))
                                                         : sample_char();
            end
            if (p == 4) begin
                pat = '0;
            end
            if (p == 7) begin
                pat = '1;
            end
            write_reg(CFG_PAT_LOW, pat[63:0]);
            write_reg(CFG_PAT_HIGH, pat[127:64]);
            // upper data bits of the length write must not matter
            lendata = (p % 3 == 0) ? {$urandom(), $urandom()} : 64'd0;
            lendata[LEN_W-1:0] = plen[LEN_W-1:0];
            write_reg(CFG_PAT_LEN, lendata);
            if (p % 4 == 1) begin
                write_reg(CFG_SPARE, {$urandom(), $urandom()});
            end
            fill_phase(PHASE_ITEMS, pat, plen);
        end

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/csc_pkg.sv
rtl/csc_front.sv
rtl/csc_back.sv
rtl/caseless_substring_counter_core.sv
bench/caseless_substring_counter_core_tb.sv
